// ----- rtl/cpdf_pkg.sv -----
package cpdf_pkg;

    localparam int unsigned LEN_W   = 13;
    localparam int unsigned IDX_W   = 12;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned GAP_W   = 8;

    localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 13'd4096;
    localparam logic [GAP_W-1:0] GAP_LIMIT_RST  = 8'd10;

    typedef struct packed {
        logic [BYTE_W-1:0] command;
        logic [LEN_W-1:0]  packet_length;
        logic              payload_valid;
        logic [BYTE_W-1:0] payload_byte;
        logic [IDX_W-1:0]  payload_index;
        logic              packet_done;
    } t_result;

endpackage

// ----- rtl/cpdf_parser.sv -----
module cpdf_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic                          i_action,
    input  logic [cpdf_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                          i_starts_transfer,
    input  logic [cpdf_pkg::LEN_W-1:0]    i_max_length,
    input  logic [cpdf_pkg::GAP_W-1:0]    i_gap_limit_ms,
    output cpdf_pkg::t_result             o_result
);

    localparam logic [1:0] PH_CMD    = 2'd0;
    localparam logic [1:0] PH_LEN_LO = 2'd1;
    localparam logic [1:0] PH_LEN_HI = 2'd2;
    localparam logic [1:0] PH_DATA   = 2'd3;

    logic [1:0]                    r_phase,   n_phase;
    logic [cpdf_pkg::BYTE_W-1:0]   r_command, n_command;
    logic [15:0]                   r_length,  n_length;
    logic [cpdf_pkg::LEN_W-1:0]    r_count,   n_count;
    logic [cpdf_pkg::GAP_W-1:0]    r_elapsed, n_elapsed;

    logic [1:0]  cur_phase;
    logic [15:0] full_length;

    always_comb begin
        n_phase     = r_phase;
        n_command   = r_command;
        n_length    = r_length;
        n_count     = r_count;
        n_elapsed   = r_elapsed;
        cur_phase   = r_phase;
        full_length = r_length | {i_data_byte, 8'd0};
        o_result    = '0;

        if (i_action) begin
            if (r_elapsed != {cpdf_pkg::GAP_W{1'b1}}) begin
                n_elapsed = r_elapsed + 1'b1;
            end
        end else begin
            // A transfer start after a long idle gap drops any partial packet.
            if (i_starts_transfer) begin
                if (r_elapsed > i_gap_limit_ms) begin
                    cur_phase = PH_CMD;
                end
                n_elapsed = '0;
            end

            unique case (cur_phase)
                PH_CMD: begin
                    n_elapsed = '0;
                    n_command = i_data_byte;
                    n_length  = '0;
                    n_count   = '0;
                    n_phase   = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_length = {8'd0, i_data_byte};
                    n_phase  = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_length = full_length;
                    n_phase  = PH_DATA;
                    if (full_length > {3'd0, i_max_length}) begin
                        n_length = '0;
                        n_phase  = PH_CMD;
                    end
                    if ({3'd0, r_count} == n_length) begin
                        o_result.packet_done = 1'b1;
                        n_phase              = PH_CMD;
                    end
                end
                PH_DATA: begin
                    if ({3'd0, r_count} < r_length) begin
                        o_result.payload_valid = 1'b1;
                        o_result.payload_byte  = i_data_byte;
                        o_result.payload_index = r_count[cpdf_pkg::IDX_W-1:0];
                        n_count                = r_count + 1'b1;
                    end
                    if ({3'd0, n_count} == r_length) begin
                        o_result.packet_done = 1'b1;
                        n_phase              = PH_CMD;
                    end
                end
                default: begin
                    n_phase = PH_CMD;
                end
            endcase

            o_result.command       = n_command;
            o_result.packet_length = n_length[cpdf_pkg::LEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_CMD;
            r_command <= '0;
            r_length  <= '0;
            r_count   <= '0;
            r_elapsed <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_command <= n_command;
            r_length  <= n_length;
            r_count   <= n_count;
            r_elapsed <= n_elapsed;
        end
    end

endmodule

// ----- rtl/command_packet_deframer.sv -----
// A received byte's result goes to the output register, or to the skid entry while output stalls.
// Throughput: one request (byte or millisecond tick) per cycle while ready; ticks give no result.
// A two-entry output buffer keeps input ready high while one result waits downstream.
// Synchronous active-low reset returns the parser to the command byte, clears the
// idle counter and the output buffer, and loads max_length 4096 and gap_limit_ms 10.
module command_packet_deframer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_action,
    input  logic [cpdf_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                          i_starts_transfer,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [cpdf_pkg::BYTE_W-1:0]   o_command,
    output logic [cpdf_pkg::LEN_W-1:0]    o_packet_length,
    output logic                          o_payload_valid,
    output logic [cpdf_pkg::BYTE_W-1:0]   o_payload_byte,
    output logic [cpdf_pkg::IDX_W-1:0]    o_payload_index,
    output logic                          o_packet_done,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [cpdf_pkg::LEN_W-1:0]    i_cfg_data
);

    localparam logic CFG_MAX_LENGTH = 1'b0;
    localparam logic CFG_GAP_LIMIT  = 1'b1;

    logic [cpdf_pkg::LEN_W-1:0] r_max_length;
    logic [cpdf_pkg::GAP_W-1:0] r_gap_limit_ms;

    cpdf_pkg::t_result r_out, r_skid, res;
    logic              r_out_valid, r_skid_valid;
    logic              in_accept, res_valid, out_pop;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_skid_valid;
    assign in_accept   = i_in_valid && o_in_ready;
    assign res_valid   = in_accept && !i_action;
    assign out_pop     = r_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length   <= cpdf_pkg::MAX_LENGTH_RST;
            r_gap_limit_ms <= cpdf_pkg::GAP_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MAX_LENGTH: r_max_length   <= i_cfg_data;
                CFG_GAP_LIMIT:  r_gap_limit_ms <= i_cfg_data[cpdf_pkg::GAP_W-1:0];
                default: ;
            endcase
        end
    end

    cpdf_parser u_parser (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (in_accept),
        .i_action          (i_action),
        .i_data_byte       (i_data_byte),
        .i_starts_transfer (i_starts_transfer),
        .i_max_length      (r_max_length),
        .i_gap_limit_ms    (r_gap_limit_ms),
        .o_result          (res)
    );

    // The skid entry only fills when a new result arrives while the output is stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (res_valid) begin
            if (r_out_valid && !out_pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_pop) begin
                r_out <= r_skid;
            end
        end else if (res_valid) begin
            if (r_out_valid && !out_pop) begin
                r_skid <= res;
            end else begin
                r_out <= res;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_command       = r_out.command;
    assign o_packet_length = r_out.packet_length;
    assign o_payload_valid = r_out.payload_valid;
    assign o_payload_byte  = r_out.payload_byte;
    assign o_payload_index = r_out.payload_index;
    assign o_packet_done   = r_out.packet_done;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a result while the output register is empty");

    a_no_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.payload_valid) |->
            (r_out.payload_byte == '0 && r_out.payload_index == '0))
        else $error("payload fields not cleared on a non-payload result");

    a_tick_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_action && !r_out_valid) |=> !r_out_valid)
        else $error("millisecond tick produced a result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_out_valid && !r_skid_valid))
        else $error("output buffer not empty after reset");

endmodule
